@@ rtl/core/interval_usage_tracker_assert.svh @@
// Assertion macros for the tracker RTL, included by the controller.
`ifndef INTERVAL_USAGE_TRACKER_ASSERT_SVH
`define INTERVAL_USAGE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted.
`define IUT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define IUT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IUT_ASSERT(lbl, clk, rst_n, prop, msg)
`define IUT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/iut_pkg.sv @@
`timescale 1ns / 1ps

package iut_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int ADDR_WIDTH    = 32;

  typedef logic [ADDR_WIDTH-1:0] addr_t;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WINDOW_START = 1'b0;
  localparam cfg_idx_t CFG_WINDOW_END   = 1'b1;

  // Status codes
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic  req_type;
    addr_t range_start;
    addr_t range_end;
  } in_item_t;

  typedef struct packed {
    logic in_use;
    logic status;
  } out_item_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_MRG,
    OP_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    addr_t    s;
    addr_t    e;
  } cell_cmd_t;

  // Contents of one cell, handed between neighbors
  typedef struct packed {
    logic  used;
    addr_t lo;
    addr_t hi;
  } cell_data_t;

endpackage

@@ rtl/core/iut_cell.sv @@
`timescale 1ns / 1ps

module iut_cell import iut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  cell_data_t left_d,
  input  logic       left_ovl,
  input  logic       left_mark,
  input  cell_data_t right_d,
  input  logic       right_ovl,
  output cell_data_t d,
  output logic       ovl,
  output logic       hit,
  output logic       mark
);

  logic  used_r, used_nxt;
  addr_t lo_r, lo_nxt;
  addr_t hi_r, hi_nxt;
  logic  ovl_r, ovl_nxt;
  logic  hit_r, hit_nxt;
  logic  gt_r, gt_nxt;
  logic  below_r, below_nxt;
  logic  is_first;

  // Head of the overlapping run: overlaps, left neighbor does not
  assign is_first = ovl_r & ~left_ovl;
  // Insertion suffix: cells above the new start, or free cells
  assign mark     = gt_r | ~used_r;

  assign d   = '{used: used_r, lo: lo_r, hi: hi_r};
  assign ovl = ovl_r;
  assign hit = hit_r;

  always_comb begin
    used_nxt  = used_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ovl_nxt   = ovl_r;
    hit_nxt   = hit_r;
    gt_nxt    = gt_r;
    below_nxt = below_r;
    case (cmd.op)
      OP_CMP: begin
        // Compare the request against this interval
        ovl_nxt   = used_r & (lo_r <= cmd.e) & (hi_r >= cmd.s);
        hit_nxt   = used_r & (lo_r <= cmd.s) & (cmd.s < hi_r);
        gt_nxt    = used_r & (lo_r > cmd.s);
        below_nxt = used_r & (hi_r < cmd.s);
      end
      OP_INS: begin
        // Open a gap: first marked cell takes the new range, the rest move right
        if (mark && !left_mark) begin
          used_nxt = 1'b1;
          lo_nxt   = cmd.s;
          hi_nxt   = cmd.e;
        end else if (mark && left_mark) begin
          used_nxt = left_d.used;
          lo_nxt   = left_d.lo;
          hi_nxt   = left_d.hi;
        end
      end
      OP_MRG: begin
        // Widen the head of the run by the request
        if (is_first) begin
          if (cmd.s < lo_r) lo_nxt = cmd.s;
          if (cmd.e > hi_r) hi_nxt = cmd.e;
        end
      end
      OP_DEL: begin
        // Absorb the next run member and close the gap it leaves
        if (is_first) begin
          if (right_d.hi > hi_r) hi_nxt = right_d.hi;
        end else if (!below_r) begin
          used_nxt = right_d.used;
          lo_nxt   = right_d.lo;
          hi_nxt   = right_d.hi;
          ovl_nxt  = right_ovl;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      ovl_r   <= 1'b0;
      hit_r   <= 1'b0;
      gt_r    <= 1'b0;
      below_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      ovl_r   <= ovl_nxt;
      hit_r   <= hit_nxt;
      gt_r    <= gt_nxt;
      below_r <= below_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

@@ rtl/core/iut_ctrl.sv @@
`timescale 1ns / 1ps
`include "interval_usage_tracker_assert.svh"

module iut_ctrl import iut_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  cfg_idx_t                 cfg_index,
  input  addr_t                    cfg_wdata,
  output cell_cmd_t                cmd,
  input  logic [MAX_INTERVALS-1:0] ovl_vec,
  input  logic [MAX_INTERVALS-1:0] hit_vec,
  input  logic                     last_used
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_DEL,
    S_RSP
  } state_t;

  state_t    state_r, state_nxt;
  logic      type_r, type_nxt;
  addr_t     s_r, s_nxt;
  addr_t     e_r, e_nxt;
  addr_t     win_start_r, win_start_nxt;
  addr_t     win_end_r, win_end_nxt;
  out_item_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      any_ovl, dup, accept;
  addr_t     clamp_s, clamp_e;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign any_ovl = |ovl_vec;
  // Second member of an overlapping run still present
  assign dup     = |(ovl_vec & {ovl_vec[MAX_INTERVALS-2:0], 1'b0});

  assign clamp_s = (in_data.range_start < win_start_r) ? win_start_r : in_data.range_start;
  assign clamp_e = (in_data.range_end > win_end_r) ? win_end_r : in_data.range_end;

  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    win_start_nxt = win_start_r;
    win_end_nxt   = win_end_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cmd.op        = OP_HOLD;
    cmd.s         = s_r;
    cmd.e         = e_r;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_START: win_start_nxt = cfg_wdata;
        CFG_WINDOW_END:   win_end_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end

    // Drop the result beat once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          type_nxt  = in_data.req_type;
          s_nxt     = (in_data.req_type == REQ_QUERY) ? in_data.range_start : clamp_s;
          e_nxt     = clamp_e;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        res_nxt   = '{in_use: 1'b0, status: STAT_DONE};
        state_nxt = S_RSP;
        if (type_r == REQ_QUERY) begin
          res_nxt.in_use = |hit_vec;
        end else if (s_r >= e_r) begin
          // empty range: nothing to do
        end else if (!any_ovl && last_used) begin
          res_nxt.status = STAT_FULL;
        end else if (any_ovl) begin
          cmd.op    = OP_MRG;
          state_nxt = S_DEL;
        end else begin
          cmd.op = OP_INS;
        end
      end
      S_DEL: begin
        if (dup) begin
          cmd.op = OP_DEL;
        end else begin
          state_nxt = S_RSP;
        end
      end
      S_RSP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      win_start_r <= '0;
      win_end_r   <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
    end
    type_r <= type_nxt;
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  `IUT_ASSERT(a_one_in_flight, clk, rst_n, accept |=> !in_ready, "second beat accepted while busy")
  `IUT_ASSERT(a_no_ins_full, clk, rst_n, (cmd.op == OP_INS) |-> !last_used, "insert into full table")
  `IUT_ASSERT(a_rsp_source, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_RSP), "result without response state")
  `IUT_ASSERT(a_query_status, clk, rst_n, out_valid_r |-> !(out_r.status && out_r.in_use), "full status on a query")

endmodule

@@ rtl/core/interval_usage_tracker.sv @@
// Interval usage tracker: keeps a sorted table of disjoint half-open address
// ranges in a row of cells and answers allocate and query requests.
// Input channel in_valid/in_ready carries one request beat (type, start, end).
// Result channel out_valid/out_ready returns one beat per request: in_use for
// a query, status (done or table full) for an allocate.
// Configuration: cfg_we writes window_start (index 0) or window_end (index 1)
// in the same cycle; write only while no request is outstanding.
// One request is handled at a time, in the states compare, decide/update,
// delete (entered only for a merge; it absorbs one further run member at a
// time, merging and shifting), and response. The next beat is taken once
// the controller is back in idle, which it enters as the result is
// registered.
// The result sits in an output register, so a new request is accepted while
// the receiver stalls; a finished result then waits until that register frees.
// Reset empties the table, opens the window to the full address range and
// drops any pending result.
`timescale 1ns / 1ps

module interval_usage_tracker import iut_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  addr_t     cfg_wdata
);

  cell_cmd_t                cmd;
  cell_data_t               cd [MAX_INTERVALS];
  cell_data_t               ld [MAX_INTERVALS];
  cell_data_t               rd [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] ovl_vec, hit_vec, mark_vec;
  logic [MAX_INTERVALS-1:0] lovl, lmark, rovl;

  // Neighbor wiring; ends of the chain see an empty cell
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      if (i == 0) begin
        ld[i]    = '0;
        lovl[i]  = 1'b0;
        lmark[i] = 1'b0;
      end else begin
        ld[i]    = cd[i-1];
        lovl[i]  = ovl_vec[i-1];
        lmark[i] = mark_vec[i-1];
      end
      if (i == MAX_INTERVALS - 1) begin
        rd[i]   = '0;
        rovl[i] = 1'b0;
      end else begin
        rd[i]   = cd[i+1];
        rovl[i] = ovl_vec[i+1];
      end
    end
  end

  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    iut_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_d    (ld[g]),
      .left_ovl  (lovl[g]),
      .left_mark (lmark[g]),
      .right_d   (rd[g]),
      .right_ovl (rovl[g]),
      .d         (cd[g]),
      .ovl       (ovl_vec[g]),
      .hit       (hit_vec[g]),
      .mark      (mark_vec[g])
    );
  end

  iut_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .ovl_vec   (ovl_vec),
    .hit_vec   (hit_vec),
    .last_used (cd[MAX_INTERVALS-1].used)
  );

endmodule
